[rtl/core/uvsg_pkg.sv]
// Package for the UV sphere vertex generator: constants, pipeline stage map,
// types and the step functions of the divider and CORDIC. No dependencies.
`timescale 1ns / 1ps
package uvsg_pkg;

   localparam int MAX_RINGS = 64;
   localparam int MIN_RINGS = 8;
   localparam int RES_SCALE = 250;

   localparam int RING_W   = 7;
   localparam int SECT_W   = 8;
   localparam int RAD_W    = 16;
   localparam int VTX_W    = 14;
   localparam int POS_W    = 18;
   localparam int NRM_W    = 16;
   localparam int TEX_W    = 16;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 168;
   localparam int RSP_USER_W = 2;

   // restoring divider: numerator width, quotient bits per stage
   localparam int DIV_W      = 40;
   localparam int DIV_PER    = 4;
   localparam int DIV_STAGES = DIV_W / DIV_PER;
   localparam int DIV_LANES  = 4;
   localparam int DVS_W      = 8;
   localparam int REM_W      = 8;

   localparam int LANE_THETA = 0;
   localparam int LANE_PHI   = 1;
   localparam int LANE_TEXU  = 2;
   localparam int LANE_TEXV  = 3;

   // CORDIC in Q3.30 radians
   localparam int CW          = 34;
   localparam int COR_STEPS   = 30;
   localparam int COR_PER     = 3;
   localparam int COR_STAGES  = COR_STEPS / COR_PER;
   localparam int TRIG_W      = 32;
   localparam int PROD_W      = 64;
   localparam int RPROD_W     = 49;

   // pipeline stage map
   localparam int ST_RED  = DIV_STAGES + 1;
   localparam int ST_POST = ST_RED + COR_STAGES + 1;
   localparam int ST_MUL  = ST_POST + 1;
   localparam int ST_RND  = ST_MUL + 1;
   localparam int ST_RMUL = ST_RND + 1;
   localparam int ST_OUT  = ST_RMUL + 1;
   localparam int DEPTH   = ST_OUT + 1;

   localparam logic signed [CW-1:0] PI_Q30       = 34'sd3373259426;
   localparam logic signed [CW-1:0] TWO_PI_Q30   = 34'sd6746518852;
   localparam logic signed [CW-1:0] HALF_PI_Q30  = 34'sd1686629713;
   localparam logic signed [CW-1:0] NHALF_PI_Q30 = -34'sd1686629713;
   localparam logic signed [CW-1:0] ONE_Q30      = 34'sd1073741824;
   localparam logic signed [CW-1:0] NONE_Q30     = -34'sd1073741824;
   localparam logic signed [CW-1:0] GAIN_INV_Q30 = 34'sd652032874;

   typedef struct packed {
      logic               pv;
      logic               qv;
      logic [VTX_W-1:0]   first;
      logic [VTX_W-1:0]   second;
      logic [RAD_W-1:0]   radius;
      logic [RING_W-1:0]  rings;
      logic [TEX_W-1:0]   tex_u;
      logic [TEX_W-1:0]   tex_v;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] acc;
   } div_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cor_type;

   typedef struct packed {
      logic                 neg;
      logic signed [CW-1:0] ang;
   } red_type;

   function automatic logic [RING_W-1:0] ring_count(logic [RAD_W-1:0] r);
      logic [23:0] p;
      logic [11:0] res;
      p   = 24'(r) * 24'(RES_SCALE);
      res = p[23:12];
      if (res < 12'(MIN_RINGS)) return RING_W'(MIN_RINGS);
      if (res > 12'(MAX_RINGS)) return RING_W'(MAX_RINGS);
      return res[RING_W-1:0];
   endfunction

   // DIV_PER steps of shift, compare and subtract; quotient bits enter at the bottom
   function automatic div_type div_step(div_type v, logic [DVS_W-1:0] d);
      div_type      r;
      logic [REM_W:0] t;
      logic         ge;
      r = v;
      for (int k = 0; k < DIV_PER; k++) begin
         t  = {r.rem, r.acc[DIV_W-1]};
         ge = (t >= {1'b0, d});
         r.rem = ge ? REM_W'(t - {1'b0, d}) : t[REM_W-1:0];
         r.acc = {r.acc[DIV_W-2:0], ge};
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] atan_lut(int k);
      case (k)
         0:  return 34'sh3243F6A8;
         1:  return 34'sh1DAC6705;
         2:  return 34'sh0FADBAFC;
         3:  return 34'sh07F56EA6;
         4:  return 34'sh03FEAB76;
         5:  return 34'sh01FFD55B;
         6:  return 34'sh00FFFAAA;
         7:  return 34'sh007FFF55;
         8:  return 34'sh003FFFEA;
         9:  return 34'sh001FFFFD;
         10: return 34'sh000FFFFF;
         11: return 34'sh0007FFFF;
         12: return 34'sh0003FFFF;
         13: return 34'sh0001FFFF;
         14: return 34'sh0000FFFF;
         15: return 34'sh00007FFF;
         16: return 34'sh00003FFF;
         17: return 34'sh00001FFF;
         18: return 34'sh00000FFF;
         19: return 34'sh000007FF;
         20: return 34'sh000003FF;
         21: return 34'sh000001FF;
         22: return 34'sh000000FF;
         23: return 34'sh0000007F;
         24: return 34'sh0000003F;
         25: return 34'sh0000001F;
         26: return 34'sh0000000F;
         27: return 34'sh00000007;
         28: return 34'sh00000003;
         29: return 34'sh00000001;
         default: return '0;
      endcase
   endfunction

   function automatic cor_type cordic_step(cor_type v, int k);
      cor_type              r;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      xs = $signed(v.x) >>> k;
      ys = $signed(v.y) >>> k;
      if (!v.z[CW-1]) begin
         r.x = $signed(v.x) - ys;
         r.y = $signed(v.y) + xs;
         r.z = $signed(v.z) - atan_lut(k);
      end else begin
         r.x = $signed(v.x) + ys;
         r.y = $signed(v.y) - xs;
         r.z = $signed(v.z) + atan_lut(k);
      end
      return r;
   endfunction

   // fold 0..2*pi into -pi/2..pi/2 and note the sign flip
   function automatic red_type reduce_angle(logic [DIV_W-1:0] q);
      red_type              r;
      logic signed [CW-1:0] a;
      a = $signed({1'b0, q[CW-2:0]});
      if (a > PI_Q30) a = a - TWO_PI_Q30;
      r.neg = 1'b0;
      if (a > HALF_PI_Q30) begin
         a = a - PI_Q30;
         r.neg = 1'b1;
      end else if (a < NHALF_PI_Q30) begin
         a = a + PI_Q30;
         r.neg = 1'b1;
      end
      r.ang = a;
      return r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] trig_out(logic signed [CW-1:0] v, logic neg);
      logic signed [CW-1:0] t;
      t = neg ? -v : v;
      if (t > ONE_Q30) t = ONE_Q30;
      if (t < NONE_Q30) t = NONE_Q30;
      return TRIG_W'(t);
   endfunction

   function automatic logic signed [TRIG_W-1:0] round30(logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = (p + 64'sd536870912) >>> 30;
      return TRIG_W'(t);
   endfunction

   function automatic logic [POS_W-1:0] sat_pos(logic signed [RPROD_W-1:0] p);
      logic signed [RPROD_W-1:0] t;
      t = (p + 49'sd536870912) >>> 30;
      if (t > 49'sd65536) t = 49'sd65536;
      if (t < -49'sd65536) t = -49'sd65536;
      return POS_W'(t);
   endfunction

   function automatic logic [NRM_W-1:0] sat_nrm(logic signed [TRIG_W-1:0] d);
      logic signed [TRIG_W-1:0] t;
      t = (d + 32'sd32768) >>> 16;
      if (t > 32'sd16384) t = 32'sd16384;
      if (t < -32'sd16384) t = -32'sd16384;
      return NRM_W'(t);
   endfunction

endpackage

[rtl/core/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator: one grid point per cycle through a pipelined
// divider, dual CORDIC and fixed-point multiply chain. Depends on uvsg_pkg.
// Stages: 10 divider stages at 4 quotient bits, 10 CORDIC stages at 3 rotations, then
// the trig, product, round, radius product and output registers.
// Throughput: one transaction per cycle; a stalled output freezes the whole pipe.
// Reset clears all valid bits and sets the radius to 1.0 (64 rings).
`timescale 1ns / 1ps
module uv_sphere_vertex_generator
   import uvsg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [RAD_W-1:0]       csr_wr_data,   // sphere_radius
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,     // ring_index, sector_index, 1 pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
   // first_vertex, second_vertex, 6 pad
   output logic [RSP_W-1:0]       rsp_tdata,
   output logic [RSP_USER_W-1:0]  rsp_tuser      // quad_valid, point_valid
);

   logic [RAD_W-1:0]  radius_ff;
   logic [RING_W-1:0] rings_ff;
   logic              en;

   logic              vld_ff  [0:DEPTH-1];
   side_type          side_ff [0:DEPTH-1];
   side_type          side_in;
   side_type          side_red_in;

   div_type div_ff [0:DIV_STAGES][0:DIV_LANES-1];
   div_type div_in [0:DIV_STAGES][0:DIV_LANES-1];
   red_type red_in [0:1];
   cor_type cor_ff [0:COR_STAGES][0:1];
   cor_type cor_in [0:COR_STAGES][0:1];
   logic    neg_ff [0:COR_STAGES][0:1];

   logic signed [TRIG_W-1:0]  st_ff, ct_ff, sp_ff, cp_ff;
   logic signed [PROD_W-1:0]  px_ff, pz_ff;
   logic signed [TRIG_W-1:0]  ctm_ff;
   logic signed [TRIG_W-1:0]  d_ff  [0:2];
   logic signed [TRIG_W-1:0]  d2_ff [0:2];
   logic signed [RPROD_W-1:0] pr_ff [0:2];
   logic [RSP_W-1:0]          out_data_ff, out_data_in;
   logic [RSP_USER_W-1:0]     out_user_ff, out_user_in;

   logic [RING_W-1:0] req_ring;
   logic [SECT_W-1:0] req_sect;
   logic [SECT_W-1:0] sectors;
   logic [15:0]       first_full;

   assign en         = !vld_ff[ST_OUT] || rsp_tready;
   assign req_tready = en;
   assign req_ring   = req_tdata[RING_W-1:0];
   assign req_sect   = req_tdata[RING_W+SECT_W-1:RING_W];
   assign sectors    = {rings_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(4096);
         rings_ff  <= RING_W'(MAX_RINGS);
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
         rings_ff  <= ring_count(csr_wr_data);
      end
   end

   // stage 0: grid tests, vertex indices, divider numerators; also the divider steps of stages 1 to DIV_STAGES
   always_comb begin
      first_full     = 16'(req_ring) * 16'(sectors + 8'd1) + 16'(req_sect);
      side_in.pv     = ({1'b0, req_ring} <= {1'b0, rings_ff}) && (req_sect <= sectors);
      side_in.qv     = (req_ring < rings_ff) && (req_sect < sectors);
      side_in.first  = first_full[VTX_W-1:0];
      side_in.second = VTX_W'(first_full + 16'(sectors) + 16'd1);
      side_in.radius = radius_ff;
      side_in.rings  = rings_ff;
      side_in.tex_u  = '0;
      side_in.tex_v  = '0;

      div_in[0][LANE_THETA].rem = '0;
      div_in[0][LANE_THETA].acc = DIV_W'(req_ring) * DIV_W'(PI_Q30)
                                  + DIV_W'(rings_ff >> 1);
      div_in[0][LANE_PHI].rem   = '0;
      div_in[0][LANE_PHI].acc   = DIV_W'(req_sect) * DIV_W'(PI_Q30)
                                  + DIV_W'(rings_ff >> 1);
      div_in[0][LANE_TEXU].rem  = '0;
      div_in[0][LANE_TEXU].acc  = (DIV_W'(req_sect) << 15) + DIV_W'(rings_ff);
      div_in[0][LANE_TEXV].rem  = '0;
      div_in[0][LANE_TEXV].acc  = (DIV_W'(req_ring) << 15) + DIV_W'(rings_ff >> 1);

      for (int s = 1; s <= DIV_STAGES; s++) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            div_in[s][l] = div_step(div_ff[s-1][l],
               (l == LANE_TEXU) ? {side_ff[s-1].rings, 1'b0}
                                : {1'b0, side_ff[s-1].rings});
         end
      end
   end

   // pick up the texture quotients as the item leaves the divider
   always_comb begin
      side_red_in       = side_ff[ST_RED-1];
      side_red_in.tex_u = div_ff[DIV_STAGES][LANE_TEXU].acc[TEX_W-1:0];
      side_red_in.tex_v = TEX_W'(17'd32768 - div_ff[DIV_STAGES][LANE_TEXV].acc[16:0]);
   end

   // angle reduction, then CORDIC rotations, COR_PER per stage
   always_comb begin
      cor_type t;
      for (int l = 0; l < 2; l++) begin
         red_in[l]      = reduce_angle(div_ff[DIV_STAGES][l].acc);
         cor_in[0][l].x = GAIN_INV_Q30;
         cor_in[0][l].y = '0;
         cor_in[0][l].z = red_in[l].ang;
      end
      for (int c = 1; c <= COR_STAGES; c++) begin
         for (int l = 0; l < 2; l++) begin
            t = cor_ff[c-1][l];
            for (int m = 0; m < COR_PER; m++) t = cordic_step(t, (c - 1) * COR_PER + m);
            cor_in[c][l] = t;
         end
      end
   end

   // output stage: round, saturate, zero points outside the grid
   always_comb begin
      out_data_in = '0;
      out_user_in = '0;
      if (side_ff[ST_RMUL].pv) begin
         out_data_in = {6'b0,
                        side_ff[ST_RMUL].second, side_ff[ST_RMUL].first,
                        side_ff[ST_RMUL].tex_v, side_ff[ST_RMUL].tex_u,
                        sat_nrm(d2_ff[2]), sat_nrm(d2_ff[1]), sat_nrm(d2_ff[0]),
                        sat_pos(pr_ff[2]), sat_pos(pr_ff[1]), sat_pos(pr_ff[0])};
         out_user_in = {1'b1, side_ff[ST_RMUL].qv};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < DEPTH; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < DEPTH; s++) begin
            if (s == ST_RED) side_ff[s] <= side_red_in;
            else side_ff[s] <= side_ff[s-1];
         end

         for (int s = 0; s <= DIV_STAGES; s++)
            for (int l = 0; l < DIV_LANES; l++) div_ff[s][l] <= div_in[s][l];

         for (int l = 0; l < 2; l++) begin
            neg_ff[0][l] <= red_in[l].neg;
            for (int c = 0; c <= COR_STAGES; c++) cor_ff[c][l] <= cor_in[c][l];
            for (int c = 1; c <= COR_STAGES; c++) neg_ff[c][l] <= neg_ff[c-1][l];
         end

         // sin on y, cos on x
         st_ff <= trig_out(cor_ff[COR_STAGES][LANE_THETA].y, neg_ff[COR_STAGES][LANE_THETA]);
         ct_ff <= trig_out(cor_ff[COR_STAGES][LANE_THETA].x, neg_ff[COR_STAGES][LANE_THETA]);
         sp_ff <= trig_out(cor_ff[COR_STAGES][LANE_PHI].y, neg_ff[COR_STAGES][LANE_PHI]);
         cp_ff <= trig_out(cor_ff[COR_STAGES][LANE_PHI].x, neg_ff[COR_STAGES][LANE_PHI]);

         px_ff  <= st_ff * cp_ff;
         pz_ff  <= st_ff * sp_ff;
         ctm_ff <= ct_ff;

         d_ff[0] <= round30(px_ff);
         d_ff[1] <= ctm_ff;
         d_ff[2] <= round30(pz_ff);

         for (int n = 0; n < 3; n++) begin
            pr_ff[n] <= $signed({1'b0, side_ff[ST_RND].radius}) * d_ff[n];
            d2_ff[n] <= d_ff[n];
         end

         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      rings_ff >= RING_W'(MIN_RINGS) && rings_ff <= RING_W'(MAX_RINGS))
      else $error("ring count out of range");

   a_quad_in_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("quad flagged on a point outside the grid");

   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("nonzero payload for a point outside the grid");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transaction missing from stage 0");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(side_ff[ST_RED]) && $stable(cor_ff[COR_STAGES][0]))
      else $error("pipeline advanced during a stall");

endmodule
